### rtl/core/per_feature_label_correlation_defines.svh
// Assertion macros used by the checker file of the correlation block.
`ifndef PER_FEATURE_LABEL_CORRELATION_DEFINES_SVH
`define PER_FEATURE_LABEL_CORRELATION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### rtl/core/pfc_pkg.sv
// Package with types, widths and codes of the per-feature correlation block.
`default_nettype none
package pfc_pkg;

	// Defaults of the top level parameters.
	localparam int FEATURE_DEPTH_DEF = 256;
	localparam int MAX_ROWS_DEF      = 65536;
	localparam int SAMPLE_BITS_DEF   = 16;

	// Field widths.
	localparam int OP_W       = 2;
	localparam int IDX_W      = 8;
	localparam int VAL_W      = 16;
	localparam int CORR_W     = 16;
	localparam int STATUS_W   = 2;
	localparam int SPREAD_W   = 16;
	localparam int FIU_W      = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Accumulator widths.
	localparam int S1_W = 33;
	localparam int S2_W = 48;
	localparam int C_W  = 50;
	localparam int D_W  = 34;

	// Widest sample after sign extension, and label deviation width.
	localparam int X_W   = 24;
	localparam int DEV_W = VAL_W + 1;

	// Row count as seen by the query engine (holds the largest row limit).
	localparam int N_MAX_W = 21;

	// Query arithmetic widths.
	localparam int MUL_A_W  = 50;
	localparam int MUL_B_W  = 36;
	localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
	localparam int NUM_W    = 72;
	localparam int ROOT_W   = NUM_W / 2;
	localparam int SPN_W    = SPREAD_W + N_MAX_W;
	localparam int DEN_W    = SPN_W + ROOT_W;
	localparam int ROUND_SH = 16;
	localparam int DIV_W    = 90;
	localparam int QUO_W    = 15;
	localparam int CNT_W    = 6;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ACCUM = 2'd0;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_ROWS     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO_SPREAD = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_INDEX   = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LABEL_MEAN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LABEL_SPREAD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FEATURES     = 2'd2;

	// Saturation limits of the Q1.15 result.
	localparam logic [CORR_W-1:0] CORR_MAX = 16'h7FFF;
	localparam logic [CORR_W-1:0] CORR_MIN = 16'h8000;

	// Input transaction.
	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] feature_index;
		logic [VAL_W-1:0] sample_value;
		logic [VAL_W-1:0] label_value;
	} in_item_t;

	// Output transaction.
	typedef struct packed {
		logic [CORR_W-1:0]   correlation;
		logic [STATUS_W-1:0] status;
	} out_item_t;

	// One feature's sums as held in the memory (two's complement bit patterns).
	typedef struct packed {
		logic [S1_W-1:0] s1;
		logic [S2_W-1:0] s2;
		logic [C_W-1:0]  c;
	} entry_t;

	// Operands handed to the query engine.
	typedef struct packed {
		entry_t               entry;
		logic [N_MAX_W-1:0]   n;
		logic [D_W-1:0]       d;
		logic [SPREAD_W-1:0]  spread;
	} qry_req_t;

endpackage
`default_nettype wire

### rtl/core/pfc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module pfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/core/pfc_mul.sv
// Shift-and-add unsigned multiplier that retires one multiplier bit per cycle.
`default_nettype none
module pfc_mul #(
	parameter int A_W = 8,
	parameter int B_W = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [A_W-1:0]     a,
	input  wire logic [B_W-1:0]     b,
	output logic                    done,
	output logic      [A_W+B_W-1:0] p
);

	localparam int P_W = A_W + B_W;
	localparam int CW  = (B_W > 1) ? $clog2(B_W) : 1;
	localparam logic [CW-1:0] LAST = CW'(B_W - 1);

	logic [P_W-1:0] a_sh_q;
	logic [B_W-1:0] b_q;
	logic [P_W-1:0] p_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;

	// One partial product is added per cycle while busy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_sh_q <= P_W'(a);
				b_q    <= b;
				p_q    <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (b_q[0]) begin
					p_q <= p_q + a_sh_q;
				end
				a_sh_q <= a_sh_q << 1;
				b_q    <= b_q >> 1;
				cnt_q  <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign p    = p_q;

endmodule
`default_nettype wire

### rtl/core/pfc_query.sv
// Query engine: builds numerator and variance, takes the root and divides.
`default_nettype none
module pfc_query (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire pfc_pkg::qry_req_t   req,
	output logic                     done,
	output pfc_pkg::out_item_t       result
);
	import pfc_pkg::*;

	typedef enum logic [3:0] {
		Q_IDLE, Q_LOAD, Q_NC, Q_SD, Q_NS, Q_SS, Q_CHECK,
		Q_SQRT, Q_DEN, Q_DIVCHK, Q_DIV, Q_DONE
	} q_state_t;

	q_state_t              state_q;
	logic [S1_W-1:0]       s1_q;
	logic [S2_W-1:0]       s2_q;
	logic [C_W-1:0]        c_q;
	logic [N_MAX_W-1:0]    n_q;
	logic [D_W-1:0]        d_q;
	logic [SPREAD_W-1:0]   spread_q;
	logic [SPN_W-1:0]      spn_q;
	logic [NUM_W-1:0]      num_q;
	logic [NUM_W-1:0]      var_q;
	logic [NUM_W-1:0]      rad_q;
	logic [ROOT_W+1:0]     rem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIV_W-1:0]      dvd_q;
	logic [DIV_W-1:0]      dvs_q;
	logic [QUO_W-1:0]      quo_q;
	logic                  neg_q;
	out_item_t             result_q;
	logic                  mul_start_q;
	logic [MUL_A_W-1:0]    mul_a_q;
	logic [MUL_B_W-1:0]    mul_b_q;
	logic                  mul_done;
	logic [MUL_P_W-1:0]    mul_p;

	// Magnitudes and signs of the stored sums.
	logic [S1_W-1:0]  s1_mag;
	logic [C_W-1:0]   c_mag;
	logic [D_W-1:0]   d_mag;
	logic [NUM_W-1:0] prod;
	logic [NUM_W-1:0] num_mag;
	logic [DEN_W-1:0] den;

	assign s1_mag  = s1_q[S1_W-1] ? (~s1_q + 1'b1) : s1_q;
	assign c_mag   = c_q[C_W-1] ? (~c_q + 1'b1) : c_q;
	assign d_mag   = d_q[D_W-1] ? (~d_q + 1'b1) : d_q;
	assign prod    = mul_p[NUM_W-1:0];
	assign num_mag = num_q[NUM_W-1] ? (~num_q + 1'b1) : num_q;
	assign den     = mul_p[DEN_W-1:0];

	// One digit step of the floor square root.
	logic [ROOT_W+1:0] rem_sh;
	logic [ROOT_W+1:0] trial;
	logic              root_ge;
	logic [ROOT_W+1:0] rem_next;
	logic [ROOT_W-1:0] root_next;

	assign rem_sh    = {rem_q[ROOT_W-1:0], rad_q[NUM_W-1 -: 2]};
	assign trial     = {root_q, 2'b01};
	assign root_ge   = (rem_sh >= trial);
	assign rem_next  = root_ge ? (rem_sh - trial) : rem_sh;
	assign root_next = {root_q[ROOT_W-2:0], root_ge};

	// One restoring division step and the signed result it completes.
	logic              div_ge;
	logic [QUO_W-1:0]  quo_next;
	logic [CORR_W-1:0] q_ext;

	assign div_ge   = (dvd_q >= dvs_q);
	assign quo_next = {quo_q[QUO_W-2:0], div_ge};
	assign q_ext    = CORR_W'(quo_next);

	pfc_mul #(
		.A_W(MUL_A_W),
		.B_W(MUL_B_W)
	) u_pfc_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start_q),
		.a     (mul_a_q),
		.b     (mul_b_q),
		.done  (mul_done),
		.p     (mul_p)
	);

	// Sequencer over the shared multiplier, the root and the divider.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= Q_IDLE;
			mul_start_q <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;
			case (state_q)
				Q_IDLE: begin
					if (start) begin
						s1_q     <= req.entry.s1;
						s2_q     <= req.entry.s2;
						c_q      <= req.entry.c;
						n_q      <= req.n;
						d_q      <= req.d;
						spread_q <= req.spread;
						spn_q    <= req.spread * req.n;
						state_q  <= Q_LOAD;
					end
				end
				Q_LOAD: begin
					mul_start_q <= 1'b1;
					mul_a_q     <= MUL_A_W'(c_mag);
					mul_b_q     <= MUL_B_W'(n_q);
					state_q     <= Q_NC;
				end
				Q_NC: begin
					if (mul_done) begin
						num_q       <= c_q[C_W-1] ? (~prod + 1'b1) : prod;
						mul_start_q <= 1'b1;
						mul_a_q     <= MUL_A_W'(d_mag);
						mul_b_q     <= MUL_B_W'(s1_mag);
						state_q     <= Q_SD;
					end
				end
				Q_SD: begin
					if (mul_done) begin
						if (d_q[D_W-1] ^ s1_q[S1_W-1]) begin
							num_q <= num_q + prod;
						end else begin
							num_q <= num_q - prod;
						end
						mul_start_q <= 1'b1;
						mul_a_q     <= MUL_A_W'(s2_q);
						mul_b_q     <= MUL_B_W'(n_q);
						state_q     <= Q_NS;
					end
				end
				Q_NS: begin
					if (mul_done) begin
						var_q       <= prod;
						mul_start_q <= 1'b1;
						mul_a_q     <= MUL_A_W'(s1_mag);
						mul_b_q     <= MUL_B_W'(s1_mag);
						state_q     <= Q_SS;
					end
				end
				Q_SS: begin
					if (mul_done) begin
						var_q   <= var_q - prod;
						state_q <= Q_CHECK;
					end
				end
				Q_CHECK: begin
					// No label spread, or a variance that is not positive.
					if (spread_q == '0 || var_q[NUM_W-1] || var_q == '0) begin
						result_q.correlation <= '0;
						result_q.status      <= ST_ZERO_SPREAD;
						state_q              <= Q_DONE;
					end else begin
						rad_q   <= var_q;
						rem_q   <= '0;
						root_q  <= '0;
						cnt_q   <= '0;
						state_q <= Q_SQRT;
					end
				end
				Q_SQRT: begin
					rad_q  <= rad_q << 2;
					rem_q  <= rem_next;
					root_q <= root_next;
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(ROOT_W - 1)) begin
						mul_start_q <= 1'b1;
						mul_a_q     <= MUL_A_W'(spn_q);
						mul_b_q     <= root_next;
						state_q     <= Q_DEN;
					end
				end
				Q_DEN: begin
					if (mul_done) begin
						dvd_q   <= DIV_W'({num_mag, ROUND_SH'(0)}) + DIV_W'(den);
						dvs_q   <= DIV_W'({den, ROUND_SH'(0)});
						neg_q   <= num_q[NUM_W-1];
						state_q <= Q_DIVCHK;
					end
				end
				Q_DIVCHK: begin
					// A quotient of 2^15 or more saturates either way.
					if (div_ge) begin
						result_q.correlation <= neg_q ? CORR_MIN : CORR_MAX;
						result_q.status      <= ST_OK;
						state_q              <= Q_DONE;
					end else begin
						dvs_q   <= dvs_q >> 1;
						quo_q   <= '0;
						cnt_q   <= '0;
						state_q <= Q_DIV;
					end
				end
				Q_DIV: begin
					if (div_ge) begin
						dvd_q <= dvd_q - dvs_q;
					end
					dvs_q <= dvs_q >> 1;
					quo_q <= quo_next;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(QUO_W - 1)) begin
						result_q.correlation <= neg_q ? (~q_ext + 1'b1) : q_ext;
						result_q.status      <= ST_OK;
						state_q              <= Q_DONE;
					end
				end
				Q_DONE: begin
					state_q <= Q_IDLE;
				end
				default: begin
					state_q <= Q_IDLE;
				end
			endcase
		end
	end

	assign done   = (state_q == Q_DONE);
	assign result = result_q;

endmodule
`default_nettype wire

### rtl/core/per_feature_label_correlation.sv
// Top level of the per-feature Pearson correlation block.
//
//  Channel | Direction | Handshake          | Transaction
//  in      | input     | in_valid/in_stall  | op, feature_index, sample_value, label_value
//  out     | output    | out_valid/out_stall| correlation, status
//  cfg     | input     | cfg_wr_en          | cfg_index, cfg_data
//
// An accumulate that lands in the memory stalls the input while its entry is read, then
// added to and written back; an ignored one does not stall it. A query answered at once
// stalls it until its result moves to the output register; a query of a valid column
// stalls it through five bit-serial multiplies, the digit-wise square root, the
// restoring divider and hand-offs. After reset and after a clear, a sweep over every
// address zeroes the memory while in_stall is high. A result waits in the output
// register; a query that finishes while it is still stalled holds until it is taken.
`default_nettype none
module per_feature_label_correlation #(
	parameter int FEATURE_DEPTH = pfc_pkg::FEATURE_DEPTH_DEF,
	parameter int MAX_ROWS      = pfc_pkg::MAX_ROWS_DEF,
	parameter int SAMPLE_BITS   = pfc_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire pfc_pkg::in_item_t                in_item,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output pfc_pkg::out_item_t                    out_item,
	input  wire logic                             cfg_wr_en,
	input  wire logic [pfc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [pfc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import pfc_pkg::*;

	localparam int AW      = (FEATURE_DEPTH > 1) ? $clog2(FEATURE_DEPTH) : 1;
	localparam int ROWS_W  = $clog2(MAX_ROWS + 1);
	localparam int ENTRY_W = $bits(entry_t);
	localparam int X_SH    = X_W - SAMPLE_BITS;
	localparam logic [AW-1:0]     LAST_ADDR  = AW'(FEATURE_DEPTH - 1);
	localparam logic [ROWS_W-1:0] MAX_ROWS_V = ROWS_W'(MAX_ROWS);
	localparam logic [12:0]       DEPTH_V    = 13'(FEATURE_DEPTH);

	typedef enum logic [2:0] {
		T_CLEAR, T_IDLE, T_ACC, T_QREAD, T_QRUN, T_RESULT
	} t_state_t;

	t_state_t             state_q;
	logic [AW-1:0]        clr_cnt_q;
	logic [ROWS_W-1:0]    row_count_q;
	logic [D_W-1:0]       dsum_q;
	logic                 row_open_q;
	logic [VAL_W-1:0]     label_mean_q;
	logic [SPREAD_W-1:0]  label_spread_q;
	logic [FIU_W-1:0]     fiu_q;
	logic [AW-1:0]        addr_q;
	logic [S1_W-1:0]      x_q;
	logic [S2_W-1:0]      xx_q;
	logic [C_W-1:0]       xd_q;
	out_item_t            res_q;
	logic                 out_valid_q;
	out_item_t            out_item_q;

	// Decode of the incoming transaction.
	logic                     accept;
	logic [IDX_W-1:0]         f;
	logic                     f_ok;
	logic [IDX_W+AW-1:0]      f_wide;
	logic [AW-1:0]            f_addr;
	logic [X_W-1:0]           x_shl;
	logic signed [X_W-1:0]    x_val;
	logic signed [DEV_W-1:0]  dev;
	logic signed [2*X_W-1:0]  xx;
	logic signed [X_W+DEV_W-1:0] xd;
	logic                     row_start_ok;
	logic                     row_open_new;

	assign accept = in_valid && !in_stall;
	assign f      = in_item.feature_index;
	assign f_ok   = (FIU_W'(f) < fiu_q) && (13'(f) < DEPTH_V);
	assign f_wide = {AW'(0), f};
	assign f_addr = f_wide[AW-1:0];

	// The sample's sign is taken at SAMPLE_BITS.
	assign x_shl = X_W'(in_item.sample_value) << X_SH;
	assign x_val = $signed(x_shl) >>> X_SH;
	assign dev   = $signed({in_item.label_value[VAL_W-1], in_item.label_value})
		- $signed({label_mean_q[VAL_W-1], label_mean_q});
	assign xx    = x_val * x_val;
	assign xd    = x_val * dev;

	assign row_start_ok = (row_count_q < MAX_ROWS_V);
	assign row_open_new = (f == '0) ? row_start_ok : row_open_q;

	// Memory of per-feature sums.
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               ram_re;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t             rd_entry;
	entry_t             acc_entry;

	assign rd_entry     = entry_t'(ram_rdata);
	assign acc_entry.s1 = rd_entry.s1 + x_q;
	assign acc_entry.s2 = rd_entry.s2 + xx_q;
	assign acc_entry.c  = rd_entry.c + xd_q;

	assign ram_re = accept && (((in_item.op == OP_ACCUM) && row_open_new && f_ok)
		|| ((in_item.op == OP_QUERY) && f_ok && (row_count_q != '0)));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = ENTRY_W'(acc_entry);
		case (state_q)
			T_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = '0;
			end
			T_ACC: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	pfc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(FEATURE_DEPTH)
	) u_pfc_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(f_addr),
		.rdata(ram_rdata)
	);

	// Query engine.
	qry_req_t  q_req;
	logic      q_start;
	logic      q_done;
	out_item_t q_result;

	assign q_start      = (state_q == T_QREAD);
	assign q_req.entry  = rd_entry;
	assign q_req.n      = N_MAX_W'(row_count_q);
	assign q_req.d      = dsum_q;
	assign q_req.spread = label_spread_q;

	pfc_query u_pfc_query (
		.clk   (clk),
		.arst_n(arst_n),
		.start (q_start),
		.req   (q_req),
		.done  (q_done),
		.result(q_result)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_mean_q   <= '0;
			label_spread_q <= SPREAD_W'(1);
			fiu_q          <= FIU_W'(256);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_LABEL_MEAN:   label_mean_q   <= cfg_data;
				CFG_LABEL_SPREAD: label_spread_q <= cfg_data;
				CFG_FEATURES:     fiu_q          <= cfg_data[FIU_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Payload registers of the accumulate path.
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= f_addr;
			x_q    <= S1_W'(x_val);
			xx_q   <= S2_W'(xx);
			xd_q   <= C_W'(xd);
		end
	end

	// Control sequencer, row bookkeeping and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_CLEAR;
			clr_cnt_q   <= '0;
			row_count_q <= '0;
			dsum_q      <= '0;
			row_open_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A taken result empties the output register unless a new one moves in.
			if (out_valid_q && !out_stall && (state_q != T_RESULT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				T_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == LAST_ADDR) begin
						state_q <= T_IDLE;
					end
				end
				T_IDLE: begin
					if (accept) begin
						case (in_item.op)
							OP_ACCUM: begin
								if (f == '0) begin
									row_open_q <= row_start_ok;
									if (row_start_ok) begin
										row_count_q <= row_count_q + 1'b1;
										dsum_q      <= dsum_q + D_W'(dev);
									end
								end
								if (row_open_new && f_ok) begin
									state_q <= T_ACC;
								end
							end
							OP_QUERY: begin
								if (!f_ok) begin
									res_q.correlation <= '0;
									res_q.status      <= ST_BAD_INDEX;
									state_q           <= T_RESULT;
								end else if (row_count_q == '0) begin
									res_q.correlation <= '0;
									res_q.status      <= ST_NO_ROWS;
									state_q           <= T_RESULT;
								end else begin
									state_q <= T_QREAD;
								end
							end
							OP_CLEAR: begin
								row_count_q <= '0;
								dsum_q      <= '0;
								row_open_q  <= 1'b0;
								clr_cnt_q   <= '0;
								state_q     <= T_CLEAR;
							end
							default: begin
							end
						endcase
					end
				end
				T_ACC: begin
					state_q <= T_IDLE;
				end
				T_QREAD: begin
					state_q <= T_QRUN;
				end
				T_QRUN: begin
					if (q_done) begin
						res_q   <= q_result;
						state_q <= T_RESULT;
					end
				end
				T_RESULT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_item_q  <= res_q;
						state_q     <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != T_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
`default_nettype wire

### rtl/core/pfc_checker.sv
// Port-level checker of the correlation block and its bind statement.
`default_nettype none
`include "per_feature_label_correlation_defines.svh"
module pfc_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_stall,
	input wire pfc_pkg::in_item_t               in_item,
	input wire logic                            out_valid,
	input wire logic                            out_stall,
	input wire pfc_pkg::out_item_t              out_item,
	input wire logic                            cfg_wr_en,
	input wire logic [pfc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input wire logic [pfc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import pfc_pkg::*;

	logic in_accept;
	logic cfg_seen;

	assign in_accept = in_valid && !in_stall;
	assign cfg_seen  = cfg_wr_en && (cfg_index == cfg_index) && (cfg_data == cfg_data);

	// A stalled result transaction stays and holds its payload.
	`PFC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_item))

	// Any status but ok comes with a zero correlation.
	`PFC_ASSERT_IMPLY(a_status_zero, clk, arst_n, out_valid, (out_item.status == ST_OK) || (out_item.correlation == '0))

	// An accepted query or clear always leaves the input stalled in the cycle after.
	`PFC_ASSERT_NEXT(a_busy_after, clk, arst_n, in_accept && ((in_item.op == OP_QUERY) || (in_item.op == OP_CLEAR)), in_stall)

	// Configuration writes do not disturb a waiting result.
	`PFC_ASSERT_NEXT(a_cfg_quiet, clk, arst_n, cfg_seen && out_valid && out_stall, out_valid)

endmodule

bind per_feature_label_correlation pfc_checker u_pfc_checker (.*);
`default_nettype wire
